// File: sv/work_rest_cycle_timer_defines.svh
// Assertion macros shared by the timer's top module and its result queue.
// Each macro assumes the module has clk_i and rst_ni in scope.
`ifndef WORK_REST_CYCLE_TIMER_DEFINES_SVH
`define WORK_REST_CYCLE_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
`define WRCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WRCT_ASSERT_NEVER(lbl, cond, msg) \
  `WRCT_ASSERT(lbl, !(cond), msg)
`else
`define WRCT_ASSERT(lbl, prop, msg)
`define WRCT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: sv/wrct_pkg.sv
`default_nettype none

package wrct_pkg;

  // Input modes.
  localparam logic [1:0] ModeTick    = 2'd0;
  localparam logic [1:0] ModeKey     = 2'd1;
  localparam logic [1:0] ModeRestart = 2'd2;

  // Result kinds.
  localparam logic [1:0] EvRestBegin = 2'd0;
  localparam logic [1:0] EvCountdown = 2'd1;
  localparam logic [1:0] EvWorkBegin = 2'd2;
  localparam logic [1:0] EvQuit      = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIndexW = 3;
  localparam logic [CfgIndexW-1:0] RegInitialRest = 3'd0;
  localparam logic [CfgIndexW-1:0] RegBreak       = 3'd1;
  localparam logic [CfgIndexW-1:0] RegWork        = 3'd2;
  localparam logic [CfgIndexW-1:0] RegPostpone    = 3'd3;
  localparam logic [CfgIndexW-1:0] RegKeyDelay    = 3'd4;

  localparam int unsigned SecW   = 17;
  localparam int unsigned RestW  = 20;
  localparam int unsigned DelayW = 8;

  localparam logic [RestW-1:0] LongRest = 20'd999999;

  // Key codes (ASCII).
  localparam logic [7:0] KeyQ      = 8'h71;
  localparam logic [7:0] KeyR      = 8'h72;
  localparam logic [7:0] KeyC      = 8'h63;
  localparam logic [7:0] KeyL      = 8'h6C;
  localparam logic [7:0] KeyB      = 8'h62;
  localparam logic [7:0] KeyUpperA = 8'h41;
  localparam logic [7:0] KeyUpperZ = 8'h5A;
  localparam logic [7:0] KeyCaseBit = 8'h20;

  // Result queue geometry.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    PhaseIdle = 2'd0,
    PhaseWork = 2'd1,
    PhaseRest = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [RestW-1:0] seconds_shown;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    phase_e            phase;
    logic [RestW-1:0]  rest_remaining;
    logic [SecW-1:0]   work_left;
    logic [DelayW-1:0] delay_left;
    logic              keys_allowed;
  } state_t;

  typedef struct packed {
    logic [SecW-1:0]   initial_rest_seconds;
    logic [SecW-1:0]   brk_len;
    logic [SecW-1:0]   work_len;
    logic [SecW-1:0]   post_len;
    logic [DelayW-1:0] key_delay_seconds;
  } cfg_t;

  // Results written into the queue at once: num is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] num;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

`default_nettype wire

// File: sv/work_rest_cycle_timer.sv
`default_nettype none

// Work/rest cycle timer. Each input item is a one-second tick, a key press or
// a restart of rest; the block keeps the phase (idle, working or resting), the
// rest countdown, the work timer and the key-enable delay, and answers each
// item with zero, one or two result items, the last one flagged by
// last_of_run. An accepted item is held in the input register and is then
// evaluated combinationally once the four-entry result queue has room for two
// results; its results can be taken on the following cycle.
// Items that cause at most one result flow at one per cycle while the output
// side takes one result per cycle; the tick that ends a rest causes two
// results, so for a stream of those the single output port limits the rate.
// The input stays ready as long as the input register is empty or the queue
// holds at most two results; it drops while an item waits for room.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write them only while no item is in flight, which
// the block does not enforce. Writes to an index above four are ignored.

`include "work_rest_cycle_timer_defines.svh"

module work_rest_cycle_timer (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [wrct_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  wire logic [wrct_pkg::SecW-1:0]            cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire wrct_pkg::in_item_t                   in_item_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output wrct_pkg::out_item_t                       out_item_o
);

  // Configuration registers.
  wrct_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_rest_seconds <= wrct_pkg::SecW'(300);
      cfg_q.brk_len              <= wrct_pkg::SecW'(300);
      cfg_q.work_len             <= wrct_pkg::SecW'(3000);
      cfg_q.post_len             <= wrct_pkg::SecW'(300);
      cfg_q.key_delay_seconds    <= wrct_pkg::DelayW'(5);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wrct_pkg::RegInitialRest: cfg_q.initial_rest_seconds <= cfg_data_i;
        wrct_pkg::RegBreak:       cfg_q.brk_len              <= cfg_data_i;
        wrct_pkg::RegWork:        cfg_q.work_len             <= cfg_data_i;
        wrct_pkg::RegPostpone:    cfg_q.post_len             <= cfg_data_i;
        wrct_pkg::RegKeyDelay:
          cfg_q.key_delay_seconds <= cfg_data_i[wrct_pkg::DelayW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register. It advances when the result queue can take two results.
  logic               in_valid_q, in_valid_d;
  wrct_pkg::in_item_t in_q;
  logic               room;
  logic               proc;
  logic               in_accept;

  assign proc       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || room;
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_valid_d = in_accept || (in_valid_q && !proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  // Timer state, updated once per evaluated item.
  wrct_pkg::state_t state_q, state_d;
  wrct_pkg::push_t  push;

  wrct_step u_step (
    .valid_i (proc),
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .push_o  (push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= wrct_pkg::PhaseIdle;
      state_q.rest_remaining <= '0;
      state_q.work_left      <= '0;
      state_q.delay_left     <= '0;
      state_q.keys_allowed   <= 1'b0;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  wrct_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Keys stay locked for as long as the key delay runs.
  `WRCT_ASSERT(a_delay_locks_keys, state_q.delay_left != '0 |-> !state_q.keys_allowed,
    "keys enabled while the key delay still runs")
  // Keys are only ever enabled by a tick that ends the delay.
  `WRCT_ASSERT(a_keys_on_tick, $rose(state_q.keys_allowed) |->
    $past(proc) && $past(in_q.mode) == wrct_pkg::ModeTick,
    "keys enabled by something other than a tick")
  // The work timer only holds time while working.
  `WRCT_ASSERT(a_work_only_working,
    state_q.work_left != '0 |-> state_q.phase == wrct_pkg::PhaseWork,
    "work timer running outside the working phase")
  // A held input item is not lost or altered while the queue lacks room for two results.
  `WRCT_ASSERT(a_hold_input, in_valid_q && !proc |=> in_valid_q && $stable(in_q),
    "stalled input item dropped or changed")

endmodule

`default_nettype wire

// File: sv/wrct_step.sv
`default_nettype none

module wrct_step (
  input  wire logic              valid_i,
  input  wire wrct_pkg::in_item_t item_i,
  input  wire wrct_pkg::state_t   state_i,
  input  wire wrct_pkg::cfg_t     cfg_i,
  output wrct_pkg::state_t        state_o,
  output wrct_pkg::push_t         push_o
);

  function automatic wrct_pkg::state_t begin_rest(
    input wrct_pkg::state_t                s,
    input logic [wrct_pkg::SecW-1:0]       secs,
    input logic [wrct_pkg::DelayW-1:0]     delay
  );
    wrct_pkg::state_t r;
    r = s;
    r.phase          = wrct_pkg::PhaseRest;
    r.rest_remaining = wrct_pkg::RestW'(secs);
    r.work_left      = '0;
    r.keys_allowed   = 1'b0;
    r.delay_left     = (delay == '0) ? wrct_pkg::DelayW'(1) : delay;
    return r;
  endfunction

  function automatic wrct_pkg::state_t begin_work(
    input wrct_pkg::state_t          s,
    input logic [wrct_pkg::SecW-1:0] secs
  );
    wrct_pkg::state_t r;
    r = s;
    r.phase      = wrct_pkg::PhaseWork;
    r.work_left  = (secs == '0) ? wrct_pkg::SecW'(1) : secs;
    r.delay_left = '0;
    return r;
  endfunction

  wrct_pkg::state_t    st;
  wrct_pkg::out_item_t ev0;
  wrct_pkg::out_item_t ev1;
  logic [1:0]          num;
  logic [7:0]          key_lc;

  always_comb begin
    st     = state_i;
    num    = 2'd0;
    ev0    = '0;
    ev1    = '0;
    key_lc = item_i.key_code;
    if (key_lc >= wrct_pkg::KeyUpperA && key_lc <= wrct_pkg::KeyUpperZ) begin
      key_lc = key_lc | wrct_pkg::KeyCaseBit;
    end

    if (valid_i) begin
      case (item_i.mode)
        wrct_pkg::ModeTick: begin
          // The key delay is served before the phase.
          if (st.delay_left != '0) begin
            st.delay_left = st.delay_left - wrct_pkg::DelayW'(1);
            if (st.delay_left == '0) begin
              st.keys_allowed = 1'b1;
            end
          end
          case (st.phase)
            wrct_pkg::PhaseRest: begin
              if (st.rest_remaining != '0) begin
                st.rest_remaining = st.rest_remaining - wrct_pkg::RestW'(1);
              end
              ev0 = '{event_kind: wrct_pkg::EvCountdown,
                      seconds_shown: st.rest_remaining, last_of_run: 1'b0};
              num = 2'd1;
              if (st.rest_remaining == '0) begin
                st  = begin_work(st, cfg_i.work_len);
                ev1 = '{event_kind: wrct_pkg::EvWorkBegin,
                        seconds_shown: '0, last_of_run: 1'b0};
                num = 2'd2;
              end
            end
            wrct_pkg::PhaseWork: begin
              if (st.work_left <= wrct_pkg::SecW'(1)) begin
                st  = begin_rest(st, cfg_i.brk_len, cfg_i.key_delay_seconds);
                ev0 = '{event_kind: wrct_pkg::EvRestBegin,
                        seconds_shown: st.rest_remaining, last_of_run: 1'b0};
                num = 2'd1;
              end else begin
                st.work_left = st.work_left - wrct_pkg::SecW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        wrct_pkg::ModeKey: begin
          if (st.keys_allowed) begin
            case (key_lc)
              wrct_pkg::KeyQ: begin
                ev0 = '{event_kind: wrct_pkg::EvQuit, seconds_shown: '0,
                        last_of_run: 1'b0};
                num = 2'd1;
              end
              wrct_pkg::KeyR: begin
                st  = begin_work(st, cfg_i.post_len);
                ev0 = '{event_kind: wrct_pkg::EvWorkBegin, seconds_shown: '0,
                        last_of_run: 1'b0};
                num = 2'd1;
              end
              wrct_pkg::KeyC: begin
                st  = begin_work(st, cfg_i.work_len);
                ev0 = '{event_kind: wrct_pkg::EvWorkBegin, seconds_shown: '0,
                        last_of_run: 1'b0};
                num = 2'd1;
              end
              wrct_pkg::KeyL: begin
                st.rest_remaining = wrct_pkg::LongRest;
                ev0 = '{event_kind: wrct_pkg::EvCountdown,
                        seconds_shown: st.rest_remaining, last_of_run: 1'b0};
                num = 2'd1;
              end
              wrct_pkg::KeyB: begin
                st  = begin_rest(st, cfg_i.brk_len, cfg_i.key_delay_seconds);
                ev0 = '{event_kind: wrct_pkg::EvRestBegin,
                        seconds_shown: st.rest_remaining, last_of_run: 1'b0};
                num = 2'd1;
              end
              default: begin
              end
            endcase
          end
        end
        wrct_pkg::ModeRestart: begin
          st  = begin_rest(st, cfg_i.initial_rest_seconds, cfg_i.key_delay_seconds);
          ev0 = '{event_kind: wrct_pkg::EvRestBegin,
                  seconds_shown: st.rest_remaining, last_of_run: 1'b0};
          num = 2'd1;
        end
        default: begin
        end
      endcase
    end

    // Flag the final result of the item.
    if (num == 2'd1) begin
      ev0.last_of_run = 1'b1;
    end
    if (num == 2'd2) begin
      ev1.last_of_run = 1'b1;
    end
  end

  assign state_o = st;
  assign push_o  = '{num: num, item0: ev0, item1: ev1};

endmodule

`default_nettype wire

// File: sv/wrct_result_fifo.sv
`default_nettype none

`include "work_rest_cycle_timer_defines.svh"

module wrct_result_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire wrct_pkg::push_t      push_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output wrct_pkg::out_item_t       out_item_o
);

  wrct_pkg::out_item_t             mem_q [wrct_pkg::FifoDepth];
  logic [wrct_pkg::PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [wrct_pkg::PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [wrct_pkg::CntW-1:0]       count_q, count_d;
  logic [wrct_pkg::PtrW-1:0]       wr_ptr_next;
  logic                            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_next = wr_ptr_q + wrct_pkg::PtrW'(1);
  assign room_o      = count_q <= wrct_pkg::CntW'(wrct_pkg::FifoDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + wrct_pkg::PtrW'(push_i.num);
  assign rd_ptr_d = rd_ptr_q + wrct_pkg::PtrW'(pop);
  assign count_d  = count_q + wrct_pkg::CntW'(push_i.num) - wrct_pkg::CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.item1;
    end
  end

  `WRCT_ASSERT_NEVER(a_count_bound, count_q > wrct_pkg::CntW'(wrct_pkg::FifoDepth),
    "result queue holds more items than its depth")
  `WRCT_ASSERT(a_push_has_room, push_i.num != 2'd0 |-> room_o,
    "results pushed into a queue without room for two")
  `WRCT_ASSERT(a_ptr_count, (wr_ptr_q - rd_ptr_q) == count_q[wrct_pkg::PtrW-1:0],
    "queue pointers disagree with the fill count")

endmodule

`default_nettype wire
